// ----- sv/hao_pkg.sv -----
// Shared constants and types for the home address option finder.
package hao_pkg;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned REM_W   = 11;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned WORD_W  = 64;

	localparam logic [DATA_W-1:0] OPT_PAD1 = 8'd0;
	localparam logic [DATA_W-1:0] OPT_HOME = 8'd201;

	// One decision of the option walker.
	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] home_addr_high;
		logic [WORD_W-1:0] home_addr_low;
	} hao_result_t;

endpackage

// ----- sv/hao_parser.sv -----
// Option walker state machine for the destination options header.
module hao_parser
	import hao_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              header_start,
	input  logic              end_of_packet,
	output logic              decided,
	output hao_result_t       result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR_LEN,
		PH_OPT_TYPE,
		PH_OPT_LEN,
		PH_SKIP,
		PH_ADDR
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [REM_W-1:0]   remaining_q, remaining_d, remaining_n, opt_len;
	logic [DATA_W-1:0]  skip_q, skip_d, skip_n;
	logic               home_q, home_d;
	logic [CNT_W-1:0]   count_q, count_d, count_n;
	logic [WORD_W-1:0]  shift_q, shift_d, shift_n;
	logic [WORD_W-1:0]  words_q, words_d;
	logic               decided_w, found_w;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		skip_d      = skip_q;
		home_d      = home_q;
		count_d     = count_q;
		shift_d     = shift_q;
		words_d     = words_q;
		decided_w   = 1'b0;
		found_w     = 1'b0;
		remaining_n = remaining_q;
		skip_n      = skip_q - 1'b1;
		count_n     = count_q + 1'b1;
		shift_n     = {shift_q[WORD_W-DATA_W-1:0], data_byte};
		opt_len     = {{(REM_W-DATA_W){1'b0}}, data_byte} + 11'd2;
		result      = '0;

		if (header_start) begin
			phase_d     = PH_HDR_LEN;
			remaining_d = '0;
			skip_d      = '0;
			home_d      = 1'b0;
			count_d     = '0;
			shift_d     = '0;
			words_d     = '0;
		end else begin
			case (phase_q)
				PH_HDR_LEN: begin
					// Area length is (len + 1) * 8 - 2, which is len * 8 + 6.
					remaining_n = {data_byte, 3'b110};
					remaining_d = remaining_n;
					if (remaining_n <= 11'd2) begin
						decided_w = 1'b1;
					end else begin
						phase_d = PH_OPT_TYPE;
					end
				end
				PH_OPT_TYPE: begin
					home_d = (data_byte == OPT_HOME);
					if (data_byte == OPT_PAD1) begin
						remaining_n = remaining_q - 1'b1;
						remaining_d = remaining_n;
						if (remaining_n <= 11'd2) begin
							decided_w = 1'b1;
						end
					end else begin
						phase_d = PH_OPT_LEN;
					end
				end
				PH_OPT_LEN: begin
					if (opt_len > remaining_q) begin
						decided_w = 1'b1;
					end else if (home_q) begin
						count_d = '0;
						shift_d = '0;
						phase_d = PH_ADDR;
					end else begin
						remaining_n = remaining_q - opt_len;
						remaining_d = remaining_n;
						skip_d      = data_byte;
						if (data_byte == '0) begin
							if (remaining_n <= 11'd2) begin
								decided_w = 1'b1;
							end else begin
								phase_d = PH_OPT_TYPE;
							end
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_n;
					if (skip_n == '0) begin
						if (remaining_q <= 11'd2) begin
							decided_w = 1'b1;
						end else begin
							phase_d = PH_OPT_TYPE;
						end
					end
				end
				PH_ADDR: begin
					count_d = count_n;
					if (count_n == 5'd8) begin
						words_d = shift_n;
						shift_d = '0;
					end else if (count_n >= 5'd16) begin
						shift_d   = shift_n;
						decided_w = 1'b1;
						found_w   = 1'b1;
					end else begin
						shift_d = shift_n;
					end
				end
				default: begin
				end
			endcase
		end

		// A packet that ends inside a header closes it with a not-found result.
		if (!decided_w && end_of_packet && phase_d != PH_IDLE) begin
			decided_w = 1'b1;
		end
		if (decided_w || end_of_packet) begin
			phase_d = PH_IDLE;
		end

		if (found_w) begin
			result.found          = 1'b1;
			result.home_addr_high = words_q;
			result.home_addr_low  = shift_n;
		end
	end

	assign decided = decided_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			skip_q      <= '0;
			home_q      <= 1'b0;
			count_q     <= '0;
			shift_q     <= '0;
			words_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			skip_q      <= skip_d;
			home_q      <= home_d;
			count_q     <= count_d;
			shift_q     <= shift_d;
			words_q     <= words_d;
		end
	end

endmodule

// ----- sv/hao_result_reg.sv -----
// Result register that holds one decision until the downstream side takes it.
module hao_result_reg
	import hao_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  hao_result_t load_data,
	output logic        slot_free,
	output logic        out_valid,
	input  logic        out_ready,
	output hao_result_t out_data
);

	logic        valid_q;
	hao_result_t data_q;

	// A held result leaves in the same cycle that a new one may enter.
	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

// ----- sv/ipv6_home_address_option_finder.sv -----
// Top level of the IPv6 destination options Home Address option finder.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_ready  data_byte, header_start, end_of_packet
//   out       response   out_valid/out_ready  found, home_addr_high, home_addr_low
//
// A byte can be accepted on every clock while in_ready is high.
// The walker state advances on the accepting edge; a decision caused by that byte
// is loaded into the result register on that same edge and stays there until it is taken.
// The request side stalls only while a result is held and out_ready is low.
// Reset (arst_n low) returns the walker to waiting for a header start and
// empties the result register.
module ipv6_home_address_option_finder
	import hao_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              header_start,
	input  logic              end_of_packet,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [WORD_W-1:0] home_addr_high,
	output logic [WORD_W-1:0] home_addr_low
);

	logic        step;
	logic        decided;
	logic        slot_free;
	hao_result_t step_result;
	hao_result_t held_result;

	// A request is taken whenever the result register can absorb a decision.
	assign in_ready = slot_free;
	assign step     = in_valid && slot_free;

	hao_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_byte),
		.header_start  (header_start),
		.end_of_packet (end_of_packet),
		.decided       (decided),
		.result        (step_result)
	);

	hao_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && decided),
		.load_data (step_result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (held_result)
	);

	assign found          = held_result.found;
	assign home_addr_high = held_result.home_addr_high;
	assign home_addr_low  = held_result.home_addr_low;

endmodule
